// ===== design/jsu_pkg.sv =====
`default_nettype none

package jsu_pkg;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    // One decoded run: up to three results, entry 0 goes out first.
    typedef struct packed {
        logic [2:0][7:0] bytes;
        kind_t           kind;
        logic [1:0]      cnt;
    } run_t;

    localparam logic [7:0] CHAR_QUOTE     = 8'h22;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_SLASH     = 8'h2F;
    localparam logic [7:0] CHAR_U         = 8'h75;
    localparam logic [7:0] CTRL_LIMIT     = 8'h20;
    localparam logic [7:0] UTF8_CONT      = 8'h80;
    localparam logic [7:0] UTF8_LEAD2     = 8'hC0;
    localparam logic [7:0] UTF8_LEAD3     = 8'hE0;
    localparam logic [5:0] UTF8_MASK      = 6'h3F;

    // {valid, value} of an ASCII hex digit, either case.
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end
        else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h57)};
        end
        else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/jsu_decoder.sv =====
`default_nettype none

module jsu_decoder
    import jsu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       commit,
    input  wire logic [7:0] text_byte,
    input  wire logic       end_of_text,
    output run_t            run
);

    typedef enum logic [3:0] {
        MODE_IDLE   = 4'b0001,
        MODE_STRING = 4'b0010,
        MODE_ESCAPE = 4'b0100,
        MODE_HEX    = 4'b1000
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic [1:0]  hex_cnt_reg, hex_cnt_next;
    logic [11:0] acc_reg, acc_next;

    logic [4:0]  hd;
    logic [15:0] code;
    logic [8:0]  esc;

    // {ok, mapped byte} for a single-letter escape
    function automatic logic [8:0] escape_map(input logic [7:0] b);
        logic [8:0] r;
        r = 9'd0;
        unique case (b)
            CHAR_QUOTE:     r = {1'b1, CHAR_QUOTE};
            CHAR_BACKSLASH: r = {1'b1, CHAR_BACKSLASH};
            CHAR_SLASH:     r = {1'b1, CHAR_SLASH};
            8'h62:          r = {1'b1, 8'h08};
            8'h66:          r = {1'b1, 8'h0C};
            8'h6E:          r = {1'b1, 8'h0A};
            8'h72:          r = {1'b1, 8'h0D};
            8'h74:          r = {1'b1, 8'h09};
            default:        r = 9'd0;
        endcase
        return r;
    endfunction

    assign hd   = hex_digit(text_byte);
    assign code = {acc_reg, hd[3:0]};
    assign esc  = escape_map(text_byte);

    always_comb
    begin
        run          = '0;
        run.kind     = KIND_BYTE;
        mode_next    = mode_reg;
        hex_cnt_next = hex_cnt_reg;
        acc_next     = acc_reg;
        if (end_of_text) begin
            mode_next    = MODE_IDLE;
            hex_cnt_next = 2'd0;
            acc_next     = 12'd0;
            run.kind     = KIND_ERROR;
            run.cnt      = 2'd1;
        end
        else begin
            unique case (mode_reg)
                MODE_IDLE:
                begin
                    if (text_byte == CHAR_QUOTE) begin
                        mode_next = MODE_STRING;
                    end
                    else begin
                        run.kind = KIND_ERROR;
                        run.cnt  = 2'd1;
                    end
                end
                MODE_STRING:
                begin
                    if (text_byte == CHAR_QUOTE) begin
                        mode_next = MODE_IDLE;
                        run.kind  = KIND_DONE;
                        run.cnt   = 2'd1;
                    end
                    else if (text_byte < CTRL_LIMIT) begin
                        mode_next = MODE_IDLE;
                        run.kind  = KIND_ERROR;
                        run.cnt   = 2'd1;
                    end
                    else if (text_byte == CHAR_BACKSLASH) begin
                        mode_next = MODE_ESCAPE;
                    end
                    else begin
                        run.bytes[0] = text_byte;
                        run.cnt      = 2'd1;
                    end
                end
                MODE_ESCAPE:
                begin
                    if (text_byte == CHAR_U) begin
                        mode_next    = MODE_HEX;
                        hex_cnt_next = 2'd0;
                        acc_next     = 12'd0;
                    end
                    else if (esc[8]) begin
                        mode_next    = MODE_STRING;
                        run.bytes[0] = esc[7:0];
                        run.cnt      = 2'd1;
                    end
                    else begin
                        mode_next = MODE_IDLE;
                        run.kind  = KIND_ERROR;
                        run.cnt   = 2'd1;
                    end
                end
                MODE_HEX:
                begin
                    if (!hd[4]) begin
                        mode_next    = MODE_IDLE;
                        hex_cnt_next = 2'd0;
                        acc_next     = 12'd0;
                        run.kind     = KIND_ERROR;
                        run.cnt      = 2'd1;
                    end
                    else if (hex_cnt_reg != 2'd3) begin
                        acc_next     = {acc_reg[7:0], hd[3:0]};
                        hex_cnt_next = hex_cnt_reg + 2'd1;
                    end
                    else begin
                        mode_next    = MODE_STRING;
                        hex_cnt_next = 2'd0;
                        acc_next     = 12'd0;
                        // encode the code unit as UTF-8, surrogates included
                        if (code[15:7] == 9'd0) begin
                            run.bytes[0] = code[7:0];
                            run.cnt      = 2'd1;
                        end
                        else if (code[15:11] == 5'd0) begin
                            run.bytes[0] = UTF8_LEAD2 | {3'd0, code[10:6]};
                            run.bytes[1] = UTF8_CONT | {2'd0, code[5:0] & UTF8_MASK};
                            run.cnt      = 2'd2;
                        end
                        else begin
                            run.bytes[0] = UTF8_LEAD3 | {4'd0, code[15:12]};
                            run.bytes[1] = UTF8_CONT | {2'd0, code[11:6] & UTF8_MASK};
                            run.bytes[2] = UTF8_CONT | {2'd0, code[5:0] & UTF8_MASK};
                            run.cnt      = 2'd3;
                        end
                    end
                end
                default:
                begin
                    mode_next    = MODE_IDLE;
                    hex_cnt_next = 2'd0;
                    acc_next     = 12'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg    <= MODE_IDLE;
            hex_cnt_reg <= 2'd0;
            acc_reg     <= 12'd0;
        end
        else if (commit) begin
            mode_reg    <= mode_next;
            hex_cnt_reg <= hex_cnt_next;
            acc_reg     <= acc_next;
        end
    end

    // digit count and accumulator are only live inside a \u escape
    a_hex_cnt_in_hex: assert property (@(posedge clk) disable iff (!rst_n)
        hex_cnt_reg != 2'd0 |-> mode_reg == MODE_HEX)
        else $error("hex digit count set outside hex mode");

    a_acc_in_hex: assert property (@(posedge clk) disable iff (!rst_n)
        acc_reg != 12'd0 |-> mode_reg == MODE_HEX)
        else $error("code accumulator set outside hex mode");

    a_eot_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        commit && end_of_text |=> mode_reg == MODE_IDLE)
        else $error("end of text did not return to idle");

endmodule

`default_nettype wire

// ===== design/jsu_result_buf.sv =====
`default_nettype none

module jsu_result_buf
    import jsu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       load,
    input  wire run_t       run,
    output logic            can_load,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic [1:0]      result_kind,
    output logic            last_of_run
);

    logic [2:0][7:0] bytes_reg;
    kind_t           kind_reg;
    logic [1:0]      cnt_reg;
    logic            pop;

    assign out_valid   = cnt_reg != 2'd0;
    assign pop         = out_valid && out_ready;
    assign last_of_run = cnt_reg == 2'd1;
    assign out_byte    = bytes_reg[0];
    assign result_kind = kind_reg;
    // take a new run once the current one is gone or leaves this cycle
    assign can_load    = (cnt_reg == 2'd0) || (last_of_run && out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= 2'd0;
        end
        else if (load) begin
            cnt_reg <= run.cnt;
        end
        else if (pop) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            bytes_reg <= run.bytes;
            kind_reg  <= run.kind;
        end
        else if (pop) begin
            bytes_reg[0] <= bytes_reg[1];
            bytes_reg[1] <= bytes_reg[2];
        end
    end

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> cnt_reg == 2'd0 || (cnt_reg == 2'd1 && out_ready))
        else $error("run loaded over pending results");

    a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind_reg != KIND_BYTE |-> last_of_run)
        else $error("done or error result not alone in its run");

    a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop && last_of_run && !load |=> !out_valid)
        else $error("buffer not empty after last result taken");

endmodule

`default_nettype wire

// ===== design/json_string_unescape.sv =====
`default_nettype none

// Channel   Handshake               Payload
// input     in_valid / in_ready     text_byte, end_of_text
// output    out_valid / out_ready   out_byte, result_kind, last_of_run
//
// An input byte is held in an input register, decoded combinationally and its
// zero to three results moved into a result buffer that drains one per cycle
// while out_ready is high. One byte per cycle is sustained while each byte
// yields at most one result and out_ready is high; longer runs hold the input.
// Reset (rst_n, async low) returns the scanner to idle and empties both stages.
// A stalled output holds the buffer; the input register then fills and
// in_ready drops until the buffer can take the next run.

module json_string_unescape
    import jsu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] text_byte,
    input  wire logic       end_of_text,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic [1:0]      result_kind,
    output logic            last_of_run
);

    logic       in_vld_reg;
    logic [7:0] byte_reg;
    logic       eot_reg;
    logic       can_load;
    logic       advance;
    run_t       run;

    assign advance  = in_vld_reg && can_load;
    assign in_ready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready) begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) begin
            byte_reg <= text_byte;
            eot_reg  <= end_of_text;
        end
    end

    jsu_decoder u_decoder (
        .clk         (clk),
        .rst_n       (rst_n),
        .commit      (advance),
        .text_byte   (byte_reg),
        .end_of_text (eot_reg),
        .run         (run)
    );

    jsu_result_buf u_result_buf (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance),
        .run         (run),
        .can_load    (can_load),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .result_kind (result_kind),
        .last_of_run (last_of_run)
    );

endmodule

`default_nettype wire

// ===== tb/sv/tb_json_string_unescape.sv =====
`default_nettype none

module tb_json_string_unescape;
    import jsu_pkg::*;

    localparam int STALL_LONG = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 8;

    localparam logic [7:0] ESC_B = 8'h62;
    localparam logic [7:0] ESC_F = 8'h66;
    localparam logic [7:0] ESC_N = 8'h6E;
    localparam logic [7:0] ESC_R = 8'h72;
    localparam logic [7:0] ESC_T = 8'h74;

    typedef enum logic [3:0] {
        SCAN_IDLE   = 4'b0001,
        SCAN_STRING = 4'b0010,
        SCAN_ESCAPE = 4'b0100,
        SCAN_HEX    = 4'b1000
    } scan_t;

    typedef struct packed {
        logic [7:0] data;
        logic       eot;
    } text_req_t;

    typedef struct packed {
        logic [7:0] data;
        kind_t      kind;
        logic       last;
    } result_t;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] text_byte = 8'h00;
    logic       end_of_text = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic [1:0] result_kind;
    logic       last_of_run;

    text_req_t  pending[$];
    result_t    expected_results[$];
    result_t    head;
    int         queued_total = 0;
    int         errors = 0;
    int         send_idle = 0;
    int         recv_idle = 0;
    int         stall_trigger = 0;
    int         stall_seen;
    int         hold_left;
    int         quiet_cycles;

    // decoder state as seen by the predictor
    scan_t       scan_mode = SCAN_IDLE;
    logic [1:0]  digits_seen = 2'd0;
    logic [11:0] code_acc = 12'd0;

    json_string_unescape dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .result_kind (result_kind),
        .last_of_run (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]})
        begin
            r = {1'b1, c[3:0]};
        end
        else if (c inside {[8'h41:8'h46], [8'h61:8'h66]})
        begin
            r = {1'b1, 4'(c[3:0] + 4'd9)};
        end
        return r;
    endfunction

    task automatic drop_to_idle();
        scan_mode = SCAN_IDLE;
        digits_seen = 2'd0;
        code_acc = 12'd0;
    endtask

    // append one result to the expected stream, not yet marked last
    task automatic expect_result(input logic [7:0] d, input kind_t k);
        result_t r;
        r.data = d;
        r.kind = k;
        r.last = 1'b0;
        expected_results.insert(expected_results.size(), r);
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic eot);
        logic [4:0] nib;
        logic [15:0] code;
        logic [7:0] mapped;
        logic       known;
        int         base_count;
        nib = hex_nibble(b);
        code = {code_acc, nib[3:0]};
        mapped = 8'h00;
        known = 1'b1;
        base_count = expected_results.size();
        if (eot)
        begin
            drop_to_idle();
            expect_result(8'h00, KIND_ERROR);
        end
        else
        begin
            case (scan_mode)
                SCAN_IDLE:
                begin
                    if (b == CHAR_QUOTE)
                        scan_mode = SCAN_STRING;
                    else
                        expect_result(8'h00, KIND_ERROR);
                end
                SCAN_STRING:
                begin
                    if (b == CHAR_QUOTE)
                    begin
                        drop_to_idle();
                        expect_result(8'h00, KIND_DONE);
                    end
                    else if (b < CTRL_LIMIT)
                    begin
                        drop_to_idle();
                        expect_result(8'h00, KIND_ERROR);
                    end
                    else if (b == CHAR_BACKSLASH)
                        scan_mode = SCAN_ESCAPE;
                    else
                        expect_result(b, KIND_BYTE);
                end
                SCAN_ESCAPE:
                begin
                    case (b)
                        CHAR_QUOTE, CHAR_BACKSLASH, CHAR_SLASH: mapped = b;
                        ESC_B: mapped = 8'h08;
                        ESC_F: mapped = 8'h0C;
                        ESC_N: mapped = 8'h0A;
                        ESC_R: mapped = 8'h0D;
                        ESC_T: mapped = 8'h09;
                        default: known = 1'b0;
                    endcase
                    if (b == CHAR_U)
                    begin
                        scan_mode = SCAN_HEX;
                        digits_seen = 2'd0;
                        code_acc = 12'd0;
                    end
                    else if (known)
                    begin
                        scan_mode = SCAN_STRING;
                        expect_result(mapped, KIND_BYTE);
                    end
                    else
                    begin
                        drop_to_idle();
                        expect_result(8'h00, KIND_ERROR);
                    end
                end
                default:
                begin
                    if (!nib[4])
                    begin
                        drop_to_idle();
                        expect_result(8'h00, KIND_ERROR);
                    end
                    else if (digits_seen != 2'd3)
                    begin
                        code_acc = {code_acc[7:0], nib[3:0]};
                        digits_seen = digits_seen + 2'd1;
                    end
                    else
                    begin
                        scan_mode = SCAN_STRING;
                        digits_seen = 2'd0;
                        code_acc = 12'd0;
                        if (code < 16'h0080)
                        begin
                            expect_result(code[7:0], KIND_BYTE);
                        end
                        else if (code < 16'h0800)
                        begin
                            expect_result(UTF8_LEAD2 | {3'b000, code[10:6]}, KIND_BYTE);
                            expect_result(UTF8_CONT | {2'b00, code[5:0]}, KIND_BYTE);
                        end
                        else
                        begin
                            expect_result(UTF8_LEAD3 | {4'h0, code[15:12]}, KIND_BYTE);
                            expect_result(UTF8_CONT | {2'b00, code[11:6]}, KIND_BYTE);
                            expect_result(UTF8_CONT | {2'b00, code[5:0]}, KIND_BYTE);
                        end
                    end
                end
            endcase
        end
        if (expected_results.size() != base_count)
            expected_results[expected_results.size() - 1].last = 1'b1;
    endtask

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // driver: present the next request once the current one is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            text_byte <= 8'h00;
            end_of_text <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_byte(text_byte, end_of_text);
            if (!in_valid || in_ready)
            begin
                if (pending.size() != 0 && $urandom_range(99) >= send_idle)
                begin
                    in_valid <= 1'b1;
                    text_byte <= pending[0].data;
                    end_of_text <= pending[0].eot;
                    void'(pending.pop_front());
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: random back-pressure, plus a long hold on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
            stall_seen <= 0;
        end
        else if (stall_trigger != stall_seen)
        begin
            stall_seen <= stall_trigger;
            hold_left <= STALL_LONG;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result expected none got byte %0h kind %0d last %0d",
                         $time, out_byte, result_kind, last_of_run);
                errors++;
            end
            else
            begin
                head = expected_results.pop_front();
                check_field("out_byte", 32'(head.data), 32'(out_byte));
                check_field("result_kind", 32'(head.kind), 32'(result_kind));
                check_field("last_of_run", 32'(head.last), 32'(last_of_run));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[json_string_unescape] ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic push_item(input logic [7:0] b, input logic eot);
        text_req_t t;
        t.data = b;
        t.eot = eot;
        pending.insert(pending.size(), t);
        queued_total++;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return 8'h30 + {4'h0, n};
        return ($urandom_range(1) ? 8'h61 : 8'h41) + {4'h0, n} - 8'd10;
    endfunction

    task automatic push_hex4(input logic [15:0] code);
        push_item(hex_char(code[15:12]), 1'b0);
        push_item(hex_char(code[11:8]), 1'b0);
        push_item(hex_char(code[7:4]), 1'b0);
        push_item(hex_char(code[3:0]), 1'b0);
    endtask

    task automatic push_content();
        logic [7:0] c;
        logic [15:0] code;
        case ($urandom_range(9))
            0, 1, 2, 3:
            begin
                c = 8'($urandom_range(8'h20, 8'h7F));
                if (c == CHAR_QUOTE || c == CHAR_BACKSLASH)
                    c = 8'h7E;
                push_item(c, 1'b0);
            end
            4, 5:
                push_item(8'($urandom_range(8'h80, 8'hFF)), 1'b0);
            6, 7:
            begin
                push_item(CHAR_BACKSLASH, 1'b0);
                case ($urandom_range(7))
                    0: c = CHAR_QUOTE;
                    1: c = CHAR_BACKSLASH;
                    2: c = CHAR_SLASH;
                    3: c = ESC_B;
                    4: c = ESC_F;
                    5: c = ESC_N;
                    6: c = ESC_R;
                    default: c = ESC_T;
                endcase
                push_item(c, 1'b0);
            end
            default:
            begin
                case ($urandom_range(2))
                    0: code = 16'($urandom_range(16'h007F));
                    1: code = 16'($urandom_range(16'h0080, 16'h07FF));
                    default: code = 16'($urandom_range(16'h0800, 16'hFFFF));
                endcase
                push_item(CHAR_BACKSLASH, 1'b0);
                push_item(CHAR_U, 1'b0);
                push_hex4(code);
            end
        endcase
    endtask

    task automatic push_broken();
        int n;
        n = $urandom_range(3);
        case ($urandom_range(5))
            0:
                push_item(8'($urandom), 1'($urandom_range(1)));
            1:
            begin
                push_item(CHAR_QUOTE, 1'b0);
                repeat (n) push_content();
                push_item(8'($urandom_range(8'h1F)), 1'b0);
            end
            2:
            begin
                push_item(CHAR_QUOTE, 1'b0);
                repeat (n) push_content();
                push_item(CHAR_BACKSLASH, 1'b0);
                push_item(8'($urandom), 1'b0);
            end
            3:
            begin
                push_item(CHAR_QUOTE, 1'b0);
                push_item(CHAR_BACKSLASH, 1'b0);
                push_item(CHAR_U, 1'b0);
                repeat (n) push_item(hex_char(4'($urandom)), 1'b0);
                push_item(8'($urandom), 1'b0);
            end
            4:
            begin
                push_item(CHAR_QUOTE, 1'b0);
                repeat (n) push_content();
                if ($urandom_range(1))
                    push_item(CHAR_BACKSLASH, 1'b0);
                push_item(8'($urandom), 1'b1);
            end
            default:
            begin
                push_item(CHAR_QUOTE, 1'b0);
                push_item(CHAR_BACKSLASH, 1'b0);
                push_item(CHAR_U, 1'b0);
                repeat (n) push_item(hex_char(4'($urandom)), 1'b0);
                push_item(8'($urandom), 1'b1);
            end
        endcase
    endtask

    task automatic fill_random(input int target);
        while (queued_total < target)
        begin
            if ($urandom_range(99) < 85)
            begin
                push_item(CHAR_QUOTE, 1'b0);
                repeat ($urandom_range(5)) push_content();
                push_item(CHAR_QUOTE, 1'b0);
            end
            else
                push_broken();
        end
    endtask

    // hold until the block has nothing left in flight
    task automatic wait_drained();
        while (pending.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle = 20;
        recv_idle = 62;
        // end of text and a bad byte while idle
        push_item(8'h5A, 1'b1);
        push_item(8'h00, 1'b0);
        // lowest and highest plain bytes, a simple escape, \u0000, \uFfFf
        push_item(CHAR_QUOTE, 1'b0);
        push_item(8'h20, 1'b0);
        push_item(8'hFF, 1'b0);
        push_item(CHAR_BACKSLASH, 1'b0);
        push_item(ESC_N, 1'b0);
        push_item(CHAR_BACKSLASH, 1'b0);
        push_item(CHAR_U, 1'b0);
        push_hex4(16'h0000);
        push_item(CHAR_BACKSLASH, 1'b0);
        push_item(CHAR_U, 1'b0);
        push_item(8'h46, 1'b0);
        push_item(8'h66, 1'b0);
        push_item(8'h46, 1'b0);
        push_item(8'h66, 1'b0);
        push_item(CHAR_QUOTE, 1'b0);
        // control byte, unknown escape, bad hex digit, end of text in a string
        push_item(CHAR_QUOTE, 1'b0);
        push_item(8'h1F, 1'b0);
        push_item(CHAR_QUOTE, 1'b0);
        push_item(CHAR_BACKSLASH, 1'b0);
        push_item(8'h78, 1'b0);
        push_item(CHAR_QUOTE, 1'b0);
        push_item(CHAR_BACKSLASH, 1'b0);
        push_item(CHAR_U, 1'b0);
        push_item(8'h31, 1'b0);
        push_item(8'h67, 1'b0);
        push_item(CHAR_QUOTE, 1'b0);
        push_item(8'h00, 1'b1);
        fill_random(110);
        wait_drained();

        send_idle = 62;
        recv_idle = 20;
        fill_random(190);
        wait_drained();

        // stall the output long enough to back up the input
        send_idle = 0;
        recv_idle = 0;
        stall_trigger = stall_trigger + 1;
        fill_random(270);
        wait_drained();

        repeat (20) @(negedge clk);
        if (errors == 0)
            $display("[json_string_unescape] OK");
        else
            $display("[json_string_unescape] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
